FILE: src/oriented_box_overlap_test_defines.svh
// Assertion macros for the checker of the box overlap test.
// Depends on nothing; included by the checker module.
`ifndef ORIENTED_BOX_OVERLAP_TEST_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_TEST_DEFINES_SVH

// Checks a property on the clock edge while reset is released.
`define OBB_ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("obb check failed");

// Checks a property on every clock edge, reset included.
`define OBB_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("obb reset check failed");

`endif

FILE: src/obb_pkg.sv
// Shared widths, types and index tables for the oriented box overlap test.
// Depends on nothing; imported by every module of the block.
package obb_pkg;
    localparam int AXIS_FRAC_BITS = 19;
    localparam int COMP_W = 21;
    localparam int FIELD_W = 3 * COMP_W;
    localparam int NUM_FIELDS = 10;
    localparam int S_DATA_W = ((NUM_FIELDS * FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W = 8;
    localparam int BIAS_W = 10;
    localparam int D_W = COMP_W + 1;
    localparam int PAB_W = 2 * COMP_W;
    localparam int PDA_W = D_W + COMP_W;
    localparam int SR_W = PAB_W + 2;
    localparam int ST_W = PDA_W + 2;
    localparam int R_W = SR_W - AXIS_FRAC_BITS;
    localparam int T_W = ST_W - AXIS_FRAC_BITS;
    localparam int AR_W = R_W;
    localparam int EAR_W = COMP_W + AR_W;
    localparam int TR_W = T_W + R_W;
    localparam int DIST_W = TR_W + 2;
    localparam int LIM_W = EAR_W + 3;
    localparam int NUM_TESTS = 15;

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic [COMP_W-1:0] ext_t;
    typedef logic signed [R_W-1:0] rot_t;
    typedef logic signed [T_W-1:0] ofs_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } stage_en_t;
endpackage

FILE: src/obb_rot.sv
// Stages one to three: unpacks a request, forms the rotation between the boxes
// and the center offset in box A's frame, both rounded. Uses obb_pkg.
module obb_rot (
    input  logic                       aclk,
    input  obb_pkg::stage_en_t         en,
    input  logic [obb_pkg::S_DATA_W-1:0] s_tdata,
    output obb_pkg::rot_t              r_out [3][3],
    output obb_pkg::ofs_t              t_out [3],
    output obb_pkg::ext_t              ea_out [3],
    output obb_pkg::ext_t              eb_out [3]
);
    import obb_pkg::*;

    comp_t a1_reg [3][3];
    comp_t b1_reg [3][3];
    logic signed [D_W-1:0] d1_reg [3];
    ext_t ea1_reg [3];
    ext_t eb1_reg [3];

    logic signed [PAB_W-1:0] pab2_reg [3][3][3];
    logic signed [PDA_W-1:0] pda2_reg [3][3];
    ext_t ea2_reg [3];
    ext_t eb2_reg [3];

    rot_t r3_reg [3][3];
    ofs_t t3_reg [3];
    ext_t ea3_reg [3];
    ext_t eb3_reg [3];

    logic signed [SR_W-1:0] sr_next [3][3];
    logic signed [ST_W-1:0] st_next [3];

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    a1_reg[i][k] <= s_tdata[FIELD_W*(1+i) + COMP_W*k +: COMP_W];
                    b1_reg[i][k] <= s_tdata[FIELD_W*(6+i) + COMP_W*k +: COMP_W];
                end
                ea1_reg[k] <= s_tdata[FIELD_W*4 + COMP_W*k +: COMP_W];
                eb1_reg[k] <= s_tdata[FIELD_W*9 + COMP_W*k +: COMP_W];
                d1_reg[k] <= D_W'(comp_t'(s_tdata[FIELD_W*5 + COMP_W*k +: COMP_W]))
                           - D_W'(comp_t'(s_tdata[COMP_W*k +: COMP_W]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        pab2_reg[i][j][k] <= PAB_W'(a1_reg[i][k]) * PAB_W'(b1_reg[j][k]);
                    end
                    pda2_reg[i][k] <= PDA_W'(d1_reg[k]) * PDA_W'(a1_reg[i][k]);
                end
            end
            ea2_reg <= ea1_reg;
            eb2_reg <= eb1_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sr_next[i][j] = SR_W'(pab2_reg[i][j][0]) + SR_W'(pab2_reg[i][j][1])
                              + SR_W'(pab2_reg[i][j][2])
                              + SR_W'(signed'(1 << (AXIS_FRAC_BITS - 1)));
            end
            st_next[i] = ST_W'(pda2_reg[i][0]) + ST_W'(pda2_reg[i][1]) + ST_W'(pda2_reg[i][2])
                       + ST_W'(signed'(1 << (AXIS_FRAC_BITS - 1)));
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r3_reg[i][j] <= R_W'(sr_next[i][j] >>> AXIS_FRAC_BITS);
                end
                t3_reg[i] <= T_W'(st_next[i] >>> AXIS_FRAC_BITS);
            end
            ea3_reg <= ea2_reg;
            eb3_reg <= eb2_reg;
        end
    end

    assign r_out = r3_reg;
    assign t_out = t3_reg;
    assign ea_out = ea3_reg;
    assign eb_out = eb3_reg;
endmodule

FILE: src/obb_proj.sv
// Stages four and five: absolute rotation plus bias, then every product that
// the fifteen axis tests need. Uses obb_pkg.
module obb_proj (
    input  logic                        aclk,
    input  obb_pkg::stage_en_t          en,
    input  logic [obb_pkg::BIAS_W-1:0]  abs_bias,
    input  obb_pkg::rot_t               r_in [3][3],
    input  obb_pkg::ofs_t               t_in [3],
    input  obb_pkg::ext_t               ea_in [3],
    input  obb_pkg::ext_t               eb_in [3],
    output logic signed [obb_pkg::TR_W-1:0] tr_out [3][3][3],
    output logic [obb_pkg::EAR_W-1:0]   ear_out [3][3][3],
    output logic [obb_pkg::EAR_W-1:0]   ebr_out [3][3][3],
    output obb_pkg::ofs_t               t_out [3],
    output obb_pkg::ext_t               ea_out [3],
    output obb_pkg::ext_t               eb_out [3]
);
    import obb_pkg::*;

    logic [AR_W-1:0] ar4_reg [3][3];
    rot_t r4_reg [3][3];
    ofs_t t4_reg [3];
    ext_t ea4_reg [3];
    ext_t eb4_reg [3];

    logic signed [TR_W-1:0] tr5_reg [3][3][3];
    logic [EAR_W-1:0] ear5_reg [3][3][3];
    logic [EAR_W-1:0] ebr5_reg [3][3][3];
    ofs_t t5_reg [3];
    ext_t ea5_reg [3];
    ext_t eb5_reg [3];

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    ar4_reg[i][j] <= (r_in[i][j] < 0 ? AR_W'(-r_in[i][j]) : AR_W'(r_in[i][j]))
                                   + AR_W'(abs_bias);
                end
            end
            r4_reg <= r_in;
            t4_reg <= t_in;
            ea4_reg <= ea_in;
            eb4_reg <= eb_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            for (int a = 0; a < 3; a++) begin
                for (int m = 0; m < 3; m++) begin
                    for (int j = 0; j < 3; j++) begin
                        tr5_reg[a][m][j] <= TR_W'(t4_reg[a]) * TR_W'(r4_reg[m][j]);
                        ear5_reg[a][m][j] <= EAR_W'(ea4_reg[a]) * EAR_W'(ar4_reg[m][j]);
                        ebr5_reg[a][m][j] <= EAR_W'(eb4_reg[a]) * EAR_W'(ar4_reg[m][j]);
                    end
                end
            end
            t5_reg <= t4_reg;
            ea5_reg <= ea4_reg;
            eb5_reg <= eb4_reg;
        end
    end

    assign tr_out = tr5_reg;
    assign ear_out = ear5_reg;
    assign ebr_out = ebr5_reg;
    assign t_out = t5_reg;
    assign ea_out = ea5_reg;
    assign eb_out = eb5_reg;
endmodule

FILE: src/obb_sat.sv
// Stages six and seven: sums the projected radii and distances of the fifteen
// axes, then compares and combines them into the overlap flag. Uses obb_pkg.
module obb_sat (
    input  logic                        aclk,
    input  obb_pkg::stage_en_t          en,
    input  logic signed [obb_pkg::TR_W-1:0] tr_in [3][3][3],
    input  logic [obb_pkg::EAR_W-1:0]   ear_in [3][3][3],
    input  logic [obb_pkg::EAR_W-1:0]   ebr_in [3][3][3],
    input  obb_pkg::ofs_t               t_in [3],
    input  obb_pkg::ext_t               ea_in [3],
    input  obb_pkg::ext_t               eb_in [3],
    output logic                        overlap
);
    import obb_pkg::*;

    logic [DIST_W-1:0] dist6_reg [NUM_TESTS];
    logic [LIM_W-1:0] lim6_reg [NUM_TESTS];
    logic overlap7_reg;

    logic [DIST_W-1:0] dist_next [NUM_TESTS];
    logic [LIM_W-1:0] lim_next [NUM_TESTS];
    logic signed [DIST_W-1:0] sum_next [NUM_TESTS];
    logic sep_next;

    always_comb begin
        for (int n = 0; n < NUM_TESTS; n++) begin
            sum_next[n] = '0;
            lim_next[n] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            sum_next[i] = DIST_W'(t_in[i]) <<< AXIS_FRAC_BITS;
            lim_next[i] = (LIM_W'(ea_in[i]) << AXIS_FRAC_BITS) + LIM_W'(ebr_in[0][i][0])
                        + LIM_W'(ebr_in[1][i][1]) + LIM_W'(ebr_in[2][i][2]);
        end
        for (int j = 0; j < 3; j++) begin
            sum_next[3+j] = DIST_W'(tr_in[0][0][j]) + DIST_W'(tr_in[1][1][j])
                          + DIST_W'(tr_in[2][2][j]);
            lim_next[3+j] = (LIM_W'(eb_in[j]) << AXIS_FRAC_BITS) + LIM_W'(ear_in[0][0][j])
                          + LIM_W'(ear_in[1][1][j]) + LIM_W'(ear_in[2][2][j]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sum_next[6+3*i+j] = DIST_W'(tr_in[PRV[i]][NXT[i]][j])
                                  - DIST_W'(tr_in[NXT[i]][PRV[i]][j]);
                lim_next[6+3*i+j] = LIM_W'(ear_in[NXT[i]][PRV[i]][j])
                                  + LIM_W'(ear_in[PRV[i]][NXT[i]][j])
                                  + LIM_W'(ebr_in[NXT[j]][i][PRV[j]])
                                  + LIM_W'(ebr_in[PRV[j]][i][NXT[j]]);
            end
        end
        for (int n = 0; n < NUM_TESTS; n++) begin
            dist_next[n] = sum_next[n] < 0 ? DIST_W'(-sum_next[n]) : DIST_W'(sum_next[n]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s6) begin
            dist6_reg <= dist_next;
            lim6_reg <= lim_next;
        end
    end

    always_comb begin
        sep_next = 1'b0;
        for (int n = 0; n < NUM_TESTS; n++) begin
            sep_next = sep_next | (dist6_reg[n] > DIST_W'(lim6_reg[n]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s7) begin
            overlap7_reg <= ~sep_next;
        end
    end

    assign overlap = overlap7_reg;
endmodule

FILE: src/oriented_box_overlap_test.sv
// Oriented box overlap test by fifteen separating axes, one box pair a request.
// An accepted request passes through the seven registered stages to the m_ side.
// Throughput: one request a cycle unless m_ stalls; each stage holds only while
// the stage after it is full and stalled, so bubbles fill under back-pressure.
// Reset (aresetn low, synchronous) empties every stage and sets abs_bias to 1.
module oriented_box_overlap_test (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [obb_pkg::BIAS_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // center_a, a_axis_first, a_axis_second, a_axis_third, half_size_a,
    // center_b, b_axis_first, b_axis_second, b_axis_third, half_size_b
    input  logic [obb_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // overlap
    output logic [obb_pkg::M_DATA_W-1:0]    m_tdata
);
    import obb_pkg::*;

    logic [BIAS_W-1:0] bias_reg;
    logic [6:0] valid_reg;
    logic [6:0] valid_next;
    logic [6:0] en_vec;
    stage_en_t en;

    rot_t r3 [3][3];
    ofs_t t3 [3];
    ext_t ea3 [3];
    ext_t eb3 [3];
    logic signed [TR_W-1:0] tr5 [3][3][3];
    logic [EAR_W-1:0] ear5 [3][3][3];
    logic [EAR_W-1:0] ebr5 [3][3][3];
    ofs_t t5 [3];
    ext_t ea5 [3];
    ext_t eb5 [3];
    logic overlap;

    always_comb begin
        en_vec[6] = ~valid_reg[6] | m_tready;
        for (int k = 5; k >= 0; k--) begin
            en_vec[k] = ~valid_reg[k] | en_vec[k+1];
        end
        valid_next[0] = en_vec[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < 7; k++) begin
            valid_next[k] = en_vec[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign en = '{s1: en_vec[0], s2: en_vec[1], s3: en_vec[2], s4: en_vec[3],
                  s5: en_vec[4], s6: en_vec[5], s7: en_vec[6]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            bias_reg <= BIAS_W'(1);
        end else begin
            valid_reg <= valid_next;
            if (cfg_we) begin
                bias_reg <= cfg_wdata;
            end
        end
    end

    obb_rot u_rot (
        .aclk    (aclk),
        .en      (en),
        .s_tdata (s_tdata),
        .r_out   (r3),
        .t_out   (t3),
        .ea_out  (ea3),
        .eb_out  (eb3)
    );

    obb_proj u_proj (
        .aclk     (aclk),
        .en       (en),
        .abs_bias (bias_reg),
        .r_in     (r3),
        .t_in     (t3),
        .ea_in    (ea3),
        .eb_in    (eb3),
        .tr_out   (tr5),
        .ear_out  (ear5),
        .ebr_out  (ebr5),
        .t_out    (t5),
        .ea_out   (ea5),
        .eb_out   (eb5)
    );

    obb_sat u_sat (
        .aclk    (aclk),
        .en      (en),
        .tr_in   (tr5),
        .ear_in  (ear5),
        .ebr_in  (ebr5),
        .t_in    (t5),
        .ea_in   (ea5),
        .eb_in   (eb5),
        .overlap (overlap)
    );

    assign s_tready = en_vec[0];
    assign m_tvalid = valid_reg[6];
    assign m_tdata = {{(M_DATA_W-1){1'b0}}, overlap};
endmodule

FILE: src/obb_check.sv
// Port-level checker for the oriented box overlap test, bound to the top level.
// Depends on obb_pkg and oriented_box_overlap_test_defines.svh.
`include "oriented_box_overlap_test_defines.svh"

module obb_check (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_we,
    input logic [obb_pkg::BIAS_W-1:0]      cfg_wdata,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [obb_pkg::S_DATA_W-1:0]    s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [obb_pkg::M_DATA_W-1:0]    m_tdata
);
    import obb_pkg::*;

    // A reset leaves no result pending.
    `OBB_ASSERT_ANY(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    // A result that is not taken stays in place.
    `OBB_ASSERT_CLK(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // With the output side free, a new request is always taken.
    `OBB_ASSERT_CLK(a_rate, aclk, aresetn, !m_tvalid || m_tready |-> s_tready)
    // Only the low bit of a result carries information.
    `OBB_ASSERT_CLK(a_pad, aclk, aresetn, m_tvalid |-> m_tdata[M_DATA_W-1:1] == '0)
endmodule

bind oriented_box_overlap_test obb_check u_obb_check (.*);
